FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker lph_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lph_pkg.sv
// Types, sizes and codes for the linear-probing hash table.
// No dependencies.
package lph_pkg;

	localparam int SLOTS      = 256;  // power of two
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ENTRY_W = 9;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef struct packed {
		logic   taken;
		logic   tomb;
		key_t   key;
		value_t value;
	} slot_t;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXISTS    = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

FILE: hw/rtl/lph_if.sv
// Command and response channels of the hash table, valid/ready handshake.
// Depends on lph_pkg.
interface lph_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] key;
	logic [31:0] key_hash;
	logic [31:0] value;

	modport source (output valid, command, key, key_hash, value, input ready);
	modport sink   (input valid, command, key, key_hash, value, output ready);
endinterface

interface lph_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [31:0]                 found_value;
	logic [lph_pkg::ENTRY_W-1:0] entry_count;

	modport source (output valid, status, found_value, entry_count, input ready);
	modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

FILE: hw/rtl/linear_probe_hash_table_top.sv
// Linear-probing hash table with tombstones: command in, one response out.
// Depends on lph_pkg and lph_if.
//
// Usage: one command is worked at a time; a new one is taken as soon as the previous
// has left the probe engine, even while its response still sits in the output register.
// Insert, find and delete visit slots one after another from hash mod SLOTS onward: the
// slot memory has one read port and the engine streams one slot per cycle through it.
// Clear and an insert into a full table go straight to the response without probing.
// Clear empties every slot at once through per-slot valid flops, so there is no clearing
// pass after reset or clear.
module linear_probe_hash_table_top (
	input  logic            clk,
	input  logic            arst_n,
	lph_cmd_if.sink         cmd,
	lph_rsp_if.source       rsp
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_RESP  = 2'd2;

	logic [1:0]      state_q;
	logic [1:0]      cmd_q;
	lph_pkg::key_t   key_q;
	lph_pkg::value_t val_q;
	lph_pkg::idx_t   pos_q;
	lph_pkg::idx_t   probes_q;
	lph_pkg::cnt_t   live_q;

	logic [1:0]      res_status_q;
	lph_pkg::value_t res_found_q;

	logic                        out_valid_q;
	logic [1:0]                  out_status_q;
	logic [31:0]                 out_found_q;
	logic [lph_pkg::ENTRY_W-1:0] out_count_q;

	lph_pkg::slot_t mem_q [lph_pkg::SLOTS];
	logic [lph_pkg::SLOTS-1:0] slot_valid_q;
	lph_pkg::slot_t rd_data_s1;
	logic           rd_valid_s1;

	lph_pkg::idx_t  rd_addr;
	lph_pkg::idx_t  start_idx;
	logic           accept;
	logic           out_free;
	logic           taken;
	logic           tomb;
	logic           key_hit;
	logic           lap_end;
	logic           wr_en;
	lph_pkg::slot_t wr_data;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign start_idx = cmd.key_hash[lph_pkg::IDX_W-1:0];

	assign taken   = rd_valid_s1 && rd_data_s1.taken;
	assign tomb    = rd_valid_s1 && rd_data_s1.tomb;
	assign key_hit = taken && (rd_data_s1.key == key_q);
	assign lap_end = (probes_q == lph_pkg::IDX_W'(lph_pkg::SLOTS - 1));

	always_comb begin
		if (state_q == S_PROBE) begin
			rd_addr = pos_q + lph_pkg::IDX_W'(1);
		end else begin
			rd_addr = start_idx;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data_s1;
		if (state_q == S_PROBE) begin
			if (cmd_q == lph_pkg::CMD_INSERT && !taken) begin
				wr_en         = 1'b1;
				wr_data.taken = 1'b1;
				wr_data.tomb  = 1'b0;
				wr_data.key   = key_q;
				wr_data.value = val_q;
			end else if (cmd_q == lph_pkg::CMD_DELETE && key_hit) begin
				wr_en         = 1'b1;
				wr_data.taken = 1'b0;
				wr_data.tomb  = 1'b1;
			end
		end
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[pos_q] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= slot_valid_q[rd_addr];
			if (accept && cmd.command == lph_pkg::CMD_CLEAR) begin
				slot_valid_q <= '0;
			end else if (wr_en) begin
				slot_valid_q[pos_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd.command;
			key_q <= lph_pkg::key_t'(cmd.key);
			val_q <= lph_pkg::value_t'(cmd.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			probes_q     <= '0;
			live_q       <= '0;
			res_status_q <= lph_pkg::ST_OK;
			res_found_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q       <= start_idx;
						probes_q    <= '0;
						res_found_q <= '0;
						if (cmd.command == lph_pkg::CMD_CLEAR) begin
							live_q       <= '0;
							res_status_q <= lph_pkg::ST_OK;
							state_q      <= S_RESP;
						end else if (cmd.command == lph_pkg::CMD_INSERT &&
							live_q >= lph_pkg::CNT_W'(lph_pkg::SLOTS)) begin
							res_status_q <= lph_pkg::ST_FULL;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (cmd_q == lph_pkg::CMD_INSERT) begin
						if (key_hit) begin
							res_status_q <= lph_pkg::ST_EXISTS;
							state_q      <= S_RESP;
						end else if (!taken) begin
							live_q       <= live_q + lph_pkg::CNT_W'(1);
							res_status_q <= lph_pkg::ST_OK;
							state_q      <= S_RESP;
						end else if (lap_end) begin
							res_status_q <= lph_pkg::ST_FULL;
							state_q      <= S_RESP;
						end else begin
							pos_q    <= rd_addr;
							probes_q <= probes_q + lph_pkg::IDX_W'(1);
						end
					end else begin
						if (key_hit) begin
							res_status_q <= lph_pkg::ST_OK;
							if (cmd_q == lph_pkg::CMD_FIND) begin
								res_found_q <= rd_data_s1.value;
							end else if (live_q != '0) begin
								live_q <= live_q - lph_pkg::CNT_W'(1);
							end
							state_q <= S_RESP;
						end else if ((!taken && !tomb) || lap_end) begin
							res_status_q <= lph_pkg::ST_NOT_FOUND;
							state_q      <= S_RESP;
						end else begin
							pos_q    <= rd_addr;
							probes_q <= probes_q + lph_pkg::IDX_W'(1);
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_found_q  <= 32'(res_found_q);
			out_count_q  <= lph_pkg::ENTRY_W'(live_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = out_found_q;
	assign rsp.entry_count = out_count_q;

endmodule

FILE: hw/rtl/lph_checker.sv
// Port-level checks on the hash table response channel, bound to the top level.
// Depends on lph_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lph_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [1:0]                  rsp_status,
	input logic [31:0]                 rsp_found_value,
	input logic [lph_pkg::ENTRY_W-1:0] rsp_entry_count
);

	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_value) && $stable(rsp_entry_count), "response changed while stalled")
	`ASSERT_IMP(a_count_max, clk, arst_n, rsp_valid, rsp_entry_count <= lph_pkg::ENTRY_W'(lph_pkg::SLOTS), "entry count above slot count")
	`ASSERT_IMP(a_found_zero, clk, arst_n, rsp_valid && rsp_status != lph_pkg::ST_OK, rsp_found_value == 32'd0, "found value set on a failed command")
	`ASSERT_IMP(a_full_count, clk, arst_n, rsp_valid && rsp_status == lph_pkg::ST_FULL, rsp_entry_count == lph_pkg::ENTRY_W'(lph_pkg::SLOTS), "table full reported below capacity")

endmodule

bind linear_probe_hash_table_top lph_checker u_lph_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value),
	.rsp_entry_count (rsp.entry_count)
);

FILE: tb/hash_table_checker.sv
// Response checker for the linear-probing hash table: keeps its own copy of the slots,
// predicts one response per accepted command and compares it with the block's.
// Depends on lph_pkg and lph_if.
module hash_table_checker
	import lph_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lph_cmd_if   cmd,
	lph_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic [1:0]         status;
		value_t             found_value;
		logic [ENTRY_W-1:0] entry_count;
	} response_t;

	logic      slot_taken [SLOTS];
	logic      slot_tomb  [SLOTS];
	key_t      slot_key   [SLOTS];
	value_t    slot_value [SLOTS];
	int        live_entries;
	response_t pending_responses [$];
	int        bad_items = 0;
	int        waiting = 0;

	assign mismatches  = bad_items;
	assign outstanding = waiting;

	function automatic void empty_slots();
		int i;
		for (i = 0; i < SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_tomb[i]  = 1'b0;
			slot_key[i]   = '0;
			slot_value[i] = '0;
		end
		live_entries = 0;
	endfunction

	// index of the live slot holding k, or -1; tombstones are stepped over
	function automatic int probe_for_key(key_t k, idx_t start);
		idx_t pos;
		int   i;
		pos = start;
		for (i = 0; i < SLOTS; i++) begin
			if (slot_taken[pos]) begin
				if (slot_key[pos] == k)
					return int'(pos);
			end else if (!slot_tomb[pos]) begin
				return -1;
			end
			pos = pos + 1'b1;
		end
		return -1;
	endfunction

	function automatic response_t apply_command(logic [1:0] op, key_t k, logic [31:0] h,
			value_t v);
		response_t r;
		idx_t      pos;
		int        hit;
		bit        stopped;
		int        i;
		r        = '0;
		r.status = ST_OK;
		pos      = idx_t'(h % SLOTS);
		case (op)
			CMD_INSERT: begin
				r.status = ST_FULL;
				if (live_entries < SLOTS) begin
					stopped = 1'b0;
					for (i = 0; i < SLOTS && !stopped; i++) begin
						if (!slot_taken[pos]) begin
							slot_key[pos]   = k;
							slot_value[pos] = v;
							slot_taken[pos] = 1'b1;
							slot_tomb[pos]  = 1'b0;
							live_entries++;
							r.status = ST_OK;
							stopped  = 1'b1;
						end else if (slot_key[pos] == k) begin
							r.status = ST_EXISTS;
							stopped  = 1'b1;
						end
						pos = pos + 1'b1;
					end
				end
			end
			CMD_FIND: begin
				hit = probe_for_key(k, pos);
				if (hit >= 0)
					r.found_value = slot_value[idx_t'(hit)];
				else
					r.status = ST_NOT_FOUND;
			end
			CMD_DELETE: begin
				hit = probe_for_key(k, pos);
				if (hit >= 0) begin
					slot_taken[idx_t'(hit)] = 1'b0;
					slot_tomb[idx_t'(hit)]  = 1'b1;
					if (live_entries > 0)
						live_entries--;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			default: begin
				empty_slots();
			end
		endcase
		r.entry_count = ENTRY_W'(live_entries);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		response_t got;
		if (!arst_n) begin
			empty_slots();
			pending_responses.delete();
			waiting = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status      = rsp.status;
				got.found_value = rsp.found_value;
				got.entry_count = rsp.entry_count;
				if (pending_responses.size() == 0) begin
					bad_items++;
					if (bad_items <= 10)
						$display("unexpected response: status %0d value %h count %0d",
							got.status, got.found_value, got.entry_count);
				end else begin
					want = pending_responses.pop_front();
					if (got.status !== want.status || got.found_value !== want.found_value ||
							got.entry_count !== want.entry_count) begin
						bad_items++;
						if (bad_items <= 10)
							$display({"response differs: expected status %0d value %h ",
								"count %0d, got status %0d value %h count %0d"},
								want.status, want.found_value, want.entry_count,
								got.status, got.found_value, got.entry_count);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				pending_responses.push_back(apply_command(cmd.command, cmd.key,
					cmd.key_hash, cmd.value));
			waiting = pending_responses.size();
		end
	end

endmodule

FILE: tb/tb_linear_probe_hash_table_top.sv
// Testbench top for the linear-probing hash table: clock, reset, command items and
// response back-pressure; the checker beside the block does the comparing.
// Depends on lph_pkg, lph_if, hash_table_checker and linear_probe_hash_table_top.
module tb_linear_probe_hash_table_top;
	import lph_pkg::*;

	localparam int POOL        = 48;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;

	lph_cmd_if cmd_ch ();
	lph_rsp_if rsp_ch ();

	int   mismatches;
	int   outstanding;
	int   sent_count = 0;
	bit   quiet = 1'b0;
	key_t pool_key  [POOL];
	idx_t pool_slot [POOL];
	key_t        fill_key  [SLOTS];
	logic [31:0] fill_hash [SLOTS];

	always #5 clk = ~clk;

	linear_probe_hash_table_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	hash_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	task automatic send(logic [1:0] op, key_t k, logic [31:0] h, value_t v);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.command  <= op;
		cmd_ch.key      <= k;
		cmd_ch.key_hash <= h;
		cmd_ch.value    <= v;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	// random upper bits, start slot fixed
	function automatic logic [31:0] hash_for(idx_t s);
		logic [31:0] h;
		h = $urandom();
		h[IDX_W-1:0] = s;
		return h;
	endfunction

	// keys clustered round one base slot so probe chains get long
	task automatic refresh_pool();
		int   i;
		idx_t base;
		base = idx_t'($urandom_range(0, SLOTS - 1));
		for (i = 0; i < POOL; i++) begin
			pool_key[i]  = $urandom();
			pool_slot[i] = idx_t'(base + $urandom_range(0, 23));
		end
		pool_key[0] = '0;
		pool_key[1] = '1;
	endtask

	task automatic mixed_ops(int n);
		int r;
		int i;
		repeat (n) begin
			r = $urandom_range(0, 99);
			i = $urandom_range(0, POOL - 1);
			if (r < 1)
				send(CMD_CLEAR, $urandom(), $urandom(), $urandom());
			else if (r < 9)
				send(2'($urandom_range(CMD_INSERT, CMD_DELETE)), $urandom(), $urandom(),
					$urandom());
			else if (r < 50)
				send(CMD_INSERT, pool_key[i], hash_for(pool_slot[i]), $urandom());
			else if (r < 78)
				send(CMD_FIND, pool_key[i], hash_for(pool_slot[i]), $urandom());
			else
				send(CMD_DELETE, pool_key[i], hash_for(pool_slot[i]), $urandom());
			if ($urandom_range(0, 49) == 0)
				pool_key[i] = $urandom();
		end
	endtask

	// fill to capacity, probe a full table, turn every slot into a tombstone, probe once more and clear
	task automatic fill_and_drain();
		int   i;
		int   j;
		key_t absent;
		idx_t base;
		send(CMD_CLEAR, $urandom(), $urandom(), $urandom());
		base = idx_t'($urandom_range(0, SLOTS - 1));
		for (i = 0; i < SLOTS; i++) begin
			fill_key[i] = $urandom();
			fill_key[i][IDX_W-1:0] = i[IDX_W-1:0];
			fill_hash[i] = ($urandom_range(0, 3) == 0) ? $urandom() :
				hash_for(idx_t'(base + $urandom_range(0, 31)));
			send(CMD_INSERT, fill_key[i], fill_hash[i], $urandom());
		end
		absent = fill_key[5] ^ 32'h8000_0000;
		send(CMD_INSERT, absent, $urandom(), $urandom());
		send(CMD_INSERT, fill_key[7], fill_hash[7], $urandom());
		send(CMD_FIND, absent, $urandom(), $urandom());
		send(CMD_DELETE, absent, $urandom(), $urandom());
		repeat (4) begin
			j = $urandom_range(0, SLOTS - 1);
			send(CMD_FIND, fill_key[j], fill_hash[j], $urandom());
		end
		repeat (12) begin
			j = $urandom_range(0, SLOTS - 1);
			send(CMD_DELETE, fill_key[j], fill_hash[j], $urandom());
			send(CMD_INSERT, fill_key[j], fill_hash[j], $urandom());
		end
		for (i = 0; i < SLOTS; i++)
			send(CMD_DELETE, fill_key[i], fill_hash[i], $urandom());
		send(CMD_FIND, absent, $urandom(), $urandom());
		send(CMD_DELETE, fill_key[3], fill_hash[3], $urandom());
		send(CMD_INSERT, absent, $urandom(), $urandom());
		send(CMD_CLEAR, $urandom(), $urandom(), $urandom());
	endtask

	initial begin
		arst_n          <= 1'b0;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.command  <= CMD_FIND;
		cmd_ch.key      <= '0;
		cmd_ch.key_hash <= '0;
		cmd_ch.value    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_FIND,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// wraps from the last slot past slot zero
		send(CMD_INSERT, 32'h0000_0001, 32'h0000_00FF, 32'hA5A5_5A5A);
		send(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FF00, 32'h1234_5678);
		send(CMD_FIND,   32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
		send(CMD_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send(CMD_DELETE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send(CMD_FIND,   32'h0000_0001, 32'h8000_00FF, 32'h0000_0000);
		send(CMD_FIND,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		// tombstone reused, duplicate further on not seen
		send(CMD_INSERT, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_0000);
		send(CMD_FIND,   32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
		send(CMD_DELETE, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
		send(CMD_FIND,   32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
		send(CMD_DELETE, 32'hDEAD_BEEF, 32'h0000_0040, 32'h0000_0000);
		send(CMD_INSERT, 32'h8000_0001, 32'h7FFF_FF02, 32'h0000_0001);
		send(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send(CMD_DELETE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		refresh_pool();
		mixed_ops(450);
		fill_and_drain();
		refresh_pool();
		mixed_ops(300);
		quiet = 1'b1;
		mixed_ops(150);

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("linear_probe_hash_table_top: match");
		else
			$display("linear_probe_hash_table_top: mismatch");
		$finish;
	end

	initial begin
		bit held;
		int k;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && sent_count >= 60) begin
				// long hold-off: the block fills and stalls its command side
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				for (k = 0; k < 400; k++) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#(CYCLE_LIMIT * 10);
		$display("linear_probe_hash_table_top: mismatch");
		$finish;
	end

endmodule
